// File: src/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants of the trial-division prime generator.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int CFG_W       = 24;
  localparam int COUNT_W     = 21;
  localparam int MIN_LIMIT   = 10;
  localparam int RESET_LIMIT = 1000000;
  localparam int FIRST_CAND  = 5;
  localparam int SEED_LO     = 2;
  localparam int SEED_HI     = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SEED  = 8'b0000_0010,
    S_LOOK  = 8'b0000_0100,
    S_RD    = 8'b0000_1000,
    S_SQ    = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_STORE = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } ptd_state_t;

endpackage

// File: src/ptd_ram.sv
// ----------------------------------------------------------------------------
// ptd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/ptd_rem_unit.sv
// ----------------------------------------------------------------------------
// ptd_rem_unit
// Bit-serial restoring remainder: one dividend bit per cycle, one
// compare-and-subtract shared across all divisor trials.
// ----------------------------------------------------------------------------
module ptd_rem_unit #(
  parameter int NUMBER_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [NUMBER_BITS-1:0] dividend,
  input  logic [NUMBER_BITS-1:0] divisor,
  output logic                   done,
  output logic [NUMBER_BITS-1:0] rem
);

  localparam int CW = $clog2(NUMBER_BITS);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [NUMBER_BITS-1:0] dvd_r, dvd_nxt;
  logic [NUMBER_BITS-1:0] dsr_r, dsr_nxt;
  logic [NUMBER_BITS-1:0] rem_r, rem_nxt;
  logic [NUMBER_BITS:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[NUMBER_BITS-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // partial remainder stays below the divisor, so it fits the word
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = NUMBER_BITS'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[NUMBER_BITS-1:0];
      end
      dvd_nxt = {dvd_r[NUMBER_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(NUMBER_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: src/prime_trial_division_generator.sv
// ----------------------------------------------------------------------------
// prime_trial_division_generator
// Prime generator on a 6k+-1 wheel, tested by trial division against a
// table of stored primes.
// ----------------------------------------------------------------------------
// A restart request seeds primes 2 and 3 and rewinds the wheel to 5; each
// later request tests the next candidate and returns one result, or, once
// the wheel is past the limit, returns a done result without a test. Each
// trial reads one table entry, squares it and, unless the square already
// exceeds the candidate, runs the bit-serial remainder unit on it. The
// block takes one request at a time; a finished result waits in the output
// register while the next request is accepted, and the final state of a
// request holds while an earlier result is still stalled there.
module prime_trial_division_generator #(
  parameter int PRIME_SLOTS = 1024,
  parameter int NUMBER_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_restart,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [NUMBER_BITS-1:0]      out_candidate,
  output logic                        out_is_prime,
  output logic [ptd_pkg::COUNT_W-1:0] out_prime_count,
  output logic                        out_done_res,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ptd_pkg::CFG_W-1:0]   cfg_data
);

  import ptd_pkg::*;

  localparam int AW    = $clog2(PRIME_SLOTS);
  localparam int SW    = $clog2(PRIME_SLOTS + 1);
  localparam int NCW   = NUMBER_BITS + 1;
  localparam int CMP_W = (NCW > CFG_W) ? NCW : CFG_W;
  localparam int SQW   = 2 * NUMBER_BITS;
  localparam logic [CFG_W-1:0] MAX_MASK =
    (NUMBER_BITS >= CFG_W) ? {CFG_W{1'b1}} : CFG_W'((64'd1 << NUMBER_BITS) - 64'd1);

  ptd_state_t state_r, state_nxt;

  logic [CFG_W-1:0]       max_r;
  logic [SW-1:0]          stored_r, stored_nxt;
  logic [SW-1:0]          idx_r, idx_nxt;
  logic [NCW-1:0]         next_cand_r, next_cand_nxt;
  logic                   step4_r, step4_nxt;
  logic [COUNT_W-1:0]     found_r, found_nxt;
  logic [NUMBER_BITS-1:0] n_r, n_nxt;
  logic [NUMBER_BITS-1:0] p_r, p_nxt;
  logic [SQW-1:0]         sq_r, sq_nxt;
  logic                   res_prime_r, res_prime_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [NUMBER_BITS-1:0] out_cand_r, out_cand_nxt;
  logic                   out_prime_r, out_prime_nxt;
  logic [COUNT_W-1:0]     out_count_r, out_count_nxt;
  logic                   out_done_r, out_done_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [NUMBER_BITS-1:0] ram_wdata;
  logic [NUMBER_BITS-1:0] ram_rdata;

  logic                   rem_start;
  logic                   rem_done;
  logic [NUMBER_BITS-1:0] rem_val;

  logic [CFG_W-1:0]       max_masked;
  logic [CMP_W-1:0]       limit_w;
  logic                   past_limit;

  ptd_ram #(
    .WIDTH(NUMBER_BITS),
    .DEPTH(PRIME_SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  ptd_rem_unit #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rem_start),
    .dividend(n_r),
    .divisor (p_r),
    .done    (rem_done),
    .rem     (rem_val)
  );

  assign max_masked = max_r & MAX_MASK;
  assign limit_w    = (max_masked < CFG_W'(MIN_LIMIT)) ? CMP_W'(MIN_LIMIT)
                                                       : CMP_W'(max_masked);
  assign past_limit = CMP_W'(next_cand_r) > limit_w;

  always_comb begin
    state_nxt     = state_r;
    stored_nxt    = stored_r;
    idx_nxt       = idx_r;
    next_cand_nxt = next_cand_r;
    step4_nxt     = step4_r;
    found_nxt     = found_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    sq_nxt        = sq_r;
    res_prime_nxt = res_prime_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    rem_start     = 1'b0;

    out_valid_nxt = out_valid_r;
    out_cand_nxt  = out_cand_r;
    out_prime_nxt = out_prime_r;
    out_count_nxt = out_count_r;
    out_done_nxt  = out_done_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          priority if (in_restart) begin
            ram_we        = 1'b1;
            ram_waddr     = '0;
            ram_wdata     = NUMBER_BITS'(SEED_LO);
            stored_nxt    = SW'(1);
            found_nxt     = COUNT_W'(1);
            next_cand_nxt = NCW'(FIRST_CAND);
            step4_nxt     = 1'b0;
            state_nxt     = S_SEED;
          end else if (past_limit) begin
            n_nxt         = '0;
            res_prime_nxt = 1'b0;
            state_nxt     = S_FIN;
          end else begin
            n_nxt     = next_cand_r[NUMBER_BITS-1:0];
            idx_nxt   = SW'(1);
            state_nxt = S_LOOK;
          end
        end
      end
      S_SEED: begin
        ram_we        = 1'b1;
        ram_waddr     = AW'(1);
        ram_wdata     = NUMBER_BITS'(SEED_HI);
        stored_nxt    = SW'(2);
        found_nxt     = COUNT_W'(2);
        n_nxt         = NUMBER_BITS'(SEED_HI);
        res_prime_nxt = 1'b1;
        state_nxt     = S_FIN;
      end
      S_LOOK: begin
        // table read is issued at idx_r here, data lands next cycle
        if (idx_r < stored_r) begin
          state_nxt = S_RD;
        end else begin
          res_prime_nxt = 1'b1;
          state_nxt     = S_STORE;
        end
      end
      S_RD: begin
        p_nxt     = ram_rdata;
        sq_nxt    = SQW'(ram_rdata) * SQW'(ram_rdata);
        state_nxt = S_SQ;
      end
      S_SQ: begin
        priority if (p_r < NUMBER_BITS'(2)) begin
          idx_nxt   = idx_r + SW'(1);
          state_nxt = S_LOOK;
        end else if (sq_r > SQW'(n_r)) begin
          res_prime_nxt = 1'b1;
          state_nxt     = S_STORE;
        end else begin
          rem_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_done) begin
          if (rem_val == '0) begin
            res_prime_nxt = 1'b0;
            state_nxt     = S_STORE;
          end else begin
            idx_nxt   = idx_r + SW'(1);
            state_nxt = S_LOOK;
          end
        end
      end
      S_STORE: begin
        if (res_prime_r) begin
          if (found_r != COUNT_MAX) begin
            found_nxt = found_r + COUNT_W'(1);
          end
          // primes beyond the table are counted but not kept
          if (stored_r < SW'(PRIME_SLOTS)) begin
            ram_we     = 1'b1;
            ram_waddr  = stored_r[AW-1:0];
            ram_wdata  = n_r;
            stored_nxt = stored_r + SW'(1);
          end
        end
        next_cand_nxt = NCW'(n_r) + (step4_r ? NCW'(4) : NCW'(2));
        step4_nxt     = !step4_r;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_cand_nxt  = n_r;
          out_prime_nxt = res_prime_r;
          out_count_nxt = found_r;
          out_done_nxt  = past_limit;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_r       <= CFG_W'(RESET_LIMIT);
      stored_r    <= '0;
      idx_r       <= '0;
      next_cand_r <= NCW'(FIRST_CAND);
      step4_r     <= 1'b0;
      found_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stored_r    <= stored_nxt;
      idx_r       <= idx_nxt;
      next_cand_r <= next_cand_nxt;
      step4_r     <= step4_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        max_r <= cfg_data;
      end
    end
    n_r         <= n_nxt;
    p_r         <= p_nxt;
    sq_r        <= sq_nxt;
    res_prime_r <= res_prime_nxt;
    out_cand_r  <= out_cand_nxt;
    out_prime_r <= out_prime_nxt;
    out_count_r <= out_count_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_candidate   = out_cand_r;
  assign out_is_prime    = out_prime_r;
  assign out_prime_count = out_count_r;
  assign out_done_res    = out_done_r;

endmodule

// File: tb/sv/prime_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_result_checker
// Watches the request, result and limit channels of the prime generator,
// predicts every result from its own trial-division model and compares.
// ----------------------------------------------------------------------------
module prime_result_checker #(
  parameter int SLOTS = 1024,
  parameter int NUM_W = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_restart,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [NUM_W-1:0]            out_candidate,
  input  logic                        out_is_prime,
  input  logic [ptd_pkg::COUNT_W-1:0] out_prime_count,
  input  logic                        out_done_res,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [ptd_pkg::CFG_W-1:0]   cfg_data,
  output int                          outstanding,
  output int                          mismatches,
  output int                          results_seen
);
  import ptd_pkg::*;

  typedef struct packed {
    logic [NUM_W-1:0]   candidate;
    logic               is_prime;
    logic [COUNT_W-1:0] count;
    logic               done;
  } prime_result_t;

  logic [NUM_W-1:0]   divisor_tab [SLOTS];
  int unsigned        stored_cnt;
  logic [NUM_W:0]     next_cand;
  bit                 step_four;
  logic [COUNT_W-1:0] found;
  logic [CFG_W-1:0]   limit_raw;
  prime_result_t      expected_results [$];

  // count saturates, the table stops growing once full
  function automatic void add_prime(logic [NUM_W-1:0] p);
    if (stored_cnt < SLOTS) begin
      divisor_tab[stored_cnt] = p;
      stored_cnt++;
    end
    if (found != COUNT_MAX) found++;
  endfunction

  // divisors from slot 1 up; only slots already written are read
  function automatic bit trial_divide(logic [63:0] n);
    logic [63:0] p;
    for (int unsigned k = 1; k < stored_cnt && k < SLOTS; k++) begin
      p = 64'(divisor_tab[k]);
      if (p < 2) continue;
      if (p * p > n) return 1'b1;
      if (n % p == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic prime_result_t predict_prime_step(logic restart);
    prime_result_t r;
    logic [63:0]   lim;
    logic [63:0]   n;
    bit            prime;
    r = '0;
    lim = (limit_raw < CFG_W'(MIN_LIMIT)) ? 64'(MIN_LIMIT) : 64'(limit_raw);
    if (restart) begin
      stored_cnt = 0;
      found = '0;
      add_prime(NUM_W'(SEED_LO));
      add_prime(NUM_W'(SEED_HI));
      next_cand = (NUM_W+1)'(FIRST_CAND);
      step_four = 1'b0;
      r.candidate = NUM_W'(SEED_HI);
      r.is_prime = 1'b1;
      r.count = found;
    end else if (64'(next_cand) > lim) begin
      // past the limit: nothing tested, state untouched
      r.count = found;
      r.done = 1'b1;
    end else begin
      n = 64'(next_cand);
      prime = trial_divide(n);
      if (prime) add_prime(n[NUM_W-1:0]);
      next_cand = (NUM_W+1)'(n + (step_four ? 64'd4 : 64'd2));
      step_four = !step_four;
      r.candidate = n[NUM_W-1:0];
      r.is_prime = prime;
      r.count = found;
      r.done = (64'(next_cand) > lim);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    // keep the log readable when the design is badly off
    if (mismatches < 50)
      $display("[%0t] result %0d: %s is %0d, expected %0d", $time, results_seen, what, got,
               want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    bit            took_in;
    bit            took_out;
    prime_result_t want;
    if (!rst_n) begin
      stored_cnt = 0;
      next_cand = (NUM_W+1)'(FIRST_CAND);
      step_four = 1'b0;
      found = '0;
      limit_raw = CFG_W'(RESET_LIMIT);
      expected_results.delete();
      outstanding <= 0;
    end else begin
      took_in = in_valid && !in_stall;
      took_out = out_valid && !out_stall;
      if (cfg_valid && cfg_ready) limit_raw = cfg_data;
      if (took_out) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unrequested result, candidate", 64'(out_candidate), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_candidate !== want.candidate)
            report_mismatch("candidate", 64'(out_candidate), 64'(want.candidate));
          if (out_is_prime !== want.is_prime)
            report_mismatch("is_prime", 64'(out_is_prime), 64'(want.is_prime));
          if (out_prime_count !== want.count)
            report_mismatch("prime_count", 64'(out_prime_count), 64'(want.count));
          if (out_done_res !== want.done)
            report_mismatch("done_res", 64'(out_done_res), 64'(want.done));
        end
        results_seen++;
      end
      if (took_in) expected_results.push_back(predict_prime_step(in_restart));
      outstanding <= outstanding + int'(took_in) - int'(took_out);
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the trial-division prime generator: directed limit and restart
// cases, random phases over several limits, and a longer run from one restart.
// ----------------------------------------------------------------------------
module tb;
  import ptd_pkg::*;

  localparam int     PRIME_SLOTS   = 1024;
  localparam int     NUMBER_BITS   = 24;
  localparam int     RANDOM_PHASES = 5;
  localparam int     PHASE_ITEMS   = 110;
  localparam int     FILL_ITEMS    = 130;
  localparam longint CYCLE_LIMIT   = 20_000_000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_restart = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [NUMBER_BITS-1:0] out_candidate;
  logic                   out_is_prime;
  logic [COUNT_W-1:0]     out_prime_count;
  logic                   out_done_res;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data = '0;

  int          pending;
  int          mismatches;
  int          results_seen;
  int unsigned sent_count;
  int unsigned restart_count;
  longint      cycle_count;
  bit          idle_on = 1'b1;

  always #6 clk = ~clk;

  prime_trial_division_generator #(
    .PRIME_SLOTS(PRIME_SLOTS),
    .NUMBER_BITS(NUMBER_BITS)
  ) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_restart(in_restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_candidate(out_candidate), .out_is_prime(out_is_prime),
    .out_prime_count(out_prime_count), .out_done_res(out_done_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  prime_result_checker #(
    .SLOTS(PRIME_SLOTS),
    .NUM_W(NUMBER_BITS)
  ) result_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_restart(in_restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_candidate(out_candidate), .out_is_prime(out_is_prime),
    .out_prime_count(out_prime_count), .out_done_res(out_done_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .outstanding(pending), .mismatches(mismatches), .results_seen(results_seen)
  );

  always @(posedge clk) begin
    out_stall <= rst_n && idle_on && ($urandom_range(0, 99) < 25);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_request(input logic restart_bit);
    while (idle_on && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart_bit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (restart_bit) restart_count++;
  endtask

  // the block is idle once every request has its result back
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // tests straight after reset, no restart: empty table, then slot 0 unused
    repeat (8) send_request(1'b0);

    // limit below the floor, runs past it and restarts mid-stream
    wait_drain();
    write_limit('0);
    send_request(1'b1);
    repeat (4) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);

    // limit lands exactly on a candidate
    wait_drain();
    write_limit(CFG_W'(11));
    send_request(1'b1);
    repeat (4) send_request(1'b0);

    wait_drain();
    write_limit('1);
    send_request(1'b1);
    repeat (4) send_request(1'b0);
    send_request(1'b1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      logic [CFG_W-1:0] lim;
      unique case (ph)
        0:       lim = CFG_W'($urandom_range(0, 9));
        1:       lim = CFG_W'($urandom_range(10, 60));
        2:       lim = CFG_W'($urandom_range(61, 400));
        3:       lim = CFG_W'($urandom_range(401, 3000));
        default: lim = CFG_W'($urandom_range(1000000, 16777215));
      endcase
      wait_drain();
      idle_on = (ph != 3);
      write_limit(lim);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == 0) send_request($urandom_range(0, 99) < 85);
        else        send_request($urandom_range(0, 99) < 3);
      end
    end

    // longer run from one restart at a high limit
    wait_drain();
    idle_on = 1'b1;
    write_limit(CFG_W'($urandom_range(9000, 16777215)));
    send_request(1'b1);
    repeat (FILL_ITEMS) send_request(1'b0);

    wait_drain();
    repeat (40) @(posedge clk);

    $display("covered %0d requests (%0d restarts), %0d results checked, %0d cycles",
             sent_count, restart_count, results_seen, cycle_count);
    $display("limits from below the floor to full scale, with and without idle gaps");
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
